### design/ascii_frame_builder_defines.svh
// ----------------------------------------------------------------------------
// ascii_frame_builder defines
// Assertion macros shared by the frame builder modules. Each macro samples
// on the rising edge of clk_i and is switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASCII_FRAME_BUILDER_DEFINES_SVH
`define ASCII_FRAME_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define AFB_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ascii_frame_builder: assertion failed");
// Expression must never be true outside reset.
`define AFB_ASSERT_NEVER(label, expr) \
  `AFB_ASSERT(label, !(expr))
`else
`define AFB_ASSERT(label, prop)
`define AFB_ASSERT_NEVER(label, expr)
`endif

`endif

### design/afb_pkg.sv
// ----------------------------------------------------------------------------
// afb_pkg
// Types, character codes and helpers shared by the ASCII frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package afb_pkg;

  localparam logic [7:0] LeadReset = 8'h41;  // 'A'
  localparam logic [7:0] ChZero    = 8'h30;  // '0'
  localparam logic [7:0] ChHexBase = 8'h57;  // 'a' - 10
  localparam logic [7:0] ChNewline = 8'h0A;

  localparam logic [6:0] LenMin = 7'd1;
  localparam logic [6:0] LenMax = 7'd99;

  // Character positions within the up to nine characters of one transfer.
  localparam logic [3:0] PosLead    = 4'd0;
  localparam logic [3:0] PosTens    = 4'd1;
  localparam logic [3:0] PosOnes    = 4'd2;
  localparam logic [3:0] PosData    = 4'd3;
  localparam logic [3:0] PosHex3    = 4'd4;
  localparam logic [3:0] PosHex2    = 4'd5;
  localparam logic [3:0] PosHex1    = 4'd6;
  localparam logic [3:0] PosHex0    = 4'd7;
  localparam logic [3:0] PosNewline = 4'd8;

  // Everything the emitter needs to write out the characters of one input.
  typedef struct packed {
    logic        header;
    logic        trailer;
    logic [7:0]  lead;
    logic [7:0]  tens_char;
    logic [7:0]  ones_char;
    logic [7:0]  data;
    logic [15:0] sum;
  } item_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nibble);
    logic [7:0] wide;
    wide = {4'b0000, nibble};
    if (nibble < 4'd10) begin
      hex_char = ChZero + wide;
    end else begin
      hex_char = ChHexBase + wide;
    end
  endfunction

endpackage

`default_nettype wire

### design/afb_emitter.sv
// ----------------------------------------------------------------------------
// afb_emitter
// Holds the characters caused by one input and sends them one per cycle
// on the output stream while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ascii_frame_builder_defines.svh"

module afb_emitter (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire afb_pkg::item_t item_i,
  output logic               can_load_o,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // [7:0] out_byte
  output logic               m_axis_tlast,  // run_last
  output logic               m_axis_tuser   // [0] frame_done
);

  logic           valid_q, valid_d;
  logic [3:0]     pos_q, pos_d;
  afb_pkg::item_t item_q;
  logic [3:0]     end_pos;
  logic           at_end;

  assign end_pos    = item_q.trailer ? afb_pkg::PosNewline : afb_pkg::PosData;
  assign at_end     = (pos_q == end_pos);
  // The holding register frees up in the cycle its final character leaves.
  assign can_load_o = !valid_q || (m_axis_tready && at_end);

  always_comb begin
    valid_d = valid_q;
    pos_d   = pos_q;
    if (load_i) begin
      valid_d = 1'b1;
      pos_d   = item_i.header ? afb_pkg::PosLead : afb_pkg::PosData;
    end else if (valid_q && m_axis_tready) begin
      if (at_end) begin
        valid_d = 1'b0;
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= afb_pkg::PosLead;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  always_comb begin
    case (pos_q)
      afb_pkg::PosLead:    m_axis_tdata = item_q.lead;
      afb_pkg::PosTens:    m_axis_tdata = item_q.tens_char;
      afb_pkg::PosOnes:    m_axis_tdata = item_q.ones_char;
      afb_pkg::PosData:    m_axis_tdata = item_q.data;
      afb_pkg::PosHex3:    m_axis_tdata = afb_pkg::hex_char(item_q.sum[15:12]);
      afb_pkg::PosHex2:    m_axis_tdata = afb_pkg::hex_char(item_q.sum[11:8]);
      afb_pkg::PosHex1:    m_axis_tdata = afb_pkg::hex_char(item_q.sum[7:4]);
      afb_pkg::PosHex0:    m_axis_tdata = afb_pkg::hex_char(item_q.sum[3:0]);
      afb_pkg::PosNewline: m_axis_tdata = afb_pkg::ChNewline;
      default:             m_axis_tdata = afb_pkg::ChNewline;
    endcase
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = at_end;
  assign m_axis_tuser  = (pos_q == afb_pkg::PosNewline);

  `AFB_ASSERT(a_pos_in_range, valid_q |-> (pos_q <= afb_pkg::PosNewline))
  `AFB_ASSERT(a_stall_holds_pos, (valid_q && !m_axis_tready) |=> $stable(pos_q))
  `AFB_ASSERT(a_done_is_last, (valid_q && m_axis_tuser) |-> m_axis_tlast)

endmodule

`default_nettype wire

### design/ascii_frame_builder.sv
// ----------------------------------------------------------------------------
// ascii_frame_builder
// Builds ASCII text frames from the payload bytes of a message.
// ----------------------------------------------------------------------------
// Input stream s_axis carries one payload byte per transfer; the length of
// the message (1 to 99, out-of-range values clamped) is taken from the first
// transfer of each frame. Output stream m_axis carries one character per
// transfer: lead letter, two decimal length digits, the payload, four
// lowercase hex digits of the 16-bit payload sum and a newline. tlast marks
// the final character caused by one input transfer, tuser the newline.
// An input is processed in the cycle it is accepted and its first character
// is offered in the next cycle. Each input produces one to nine characters,
// sent at one per cycle while the receiver is ready; the position counter
// that steps through the held characters sets that rate. The next input
// is taken in the same cycle the last character of the previous one
// leaves. When the receiver stalls, the current character is held and the
// input stream stalls once that character set is waiting. Reset returns the
// block to awaiting a frame's first byte and sets the lead letter to 'A'.
// cfg_we_i writes cfg_wdata_i into the lead letter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ascii_frame_builder_defines.svh"

module ascii_frame_builder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [7:0] data_byte, [14:8] frame_length
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
  output logic             m_axis_tlast,  // run_last
  output logic             m_axis_tuser   // [0] frame_done
);

  logic [7:0]  lead_q;
  logic        in_frame_q, in_frame_d;
  logic [6:0]  count_q, count_d;
  logic [6:0]  len_q, len_d;
  logic [15:0] sum_q, sum_d;

  logic        accept;
  logic [7:0]  data_in;
  logic [6:0]  len_in, len_sat, len_eff;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10, ones;
  logic [6:0]  count_nx;
  logic [15:0] sum_nx;
  logic        last;
  afb_pkg::item_t item;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign data_in = s_axis_tdata[7:0];
  assign len_in  = s_axis_tdata[14:8];

  always_comb begin
    if (len_in == 7'd0) begin
      len_sat = afb_pkg::LenMin;
    end else if (len_in > afb_pkg::LenMax) begin
      len_sat = afb_pkg::LenMax;
    end else begin
      len_sat = len_in;
    end
  end

  // Divide by ten through the reciprocal 205/2048, exact for every 7-bit input, 0 to 127.
  assign tens_prod = {8'd0, len_sat} * 15'd205;
  assign tens      = tens_prod[14:11];
  assign tens_x10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
  assign ones      = len_sat - tens_x10;

  assign len_eff  = in_frame_q ? len_q : len_sat;
  assign count_nx = (in_frame_q ? count_q : 7'd0) + 7'd1;
  assign sum_nx   = (in_frame_q ? sum_q : 16'd0) + {8'd0, data_in};
  assign last     = (count_nx >= len_eff);

  always_comb begin
    item.header    = !in_frame_q;
    item.trailer   = last;
    item.lead      = lead_q;
    item.tens_char = afb_pkg::ChZero | {4'b0000, tens};
    item.ones_char = afb_pkg::ChZero | {4'b0000, ones[3:0]};
    item.data      = data_in;
    item.sum       = sum_nx;
  end

  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    len_d      = len_q;
    sum_d      = sum_q;
    if (accept) begin
      in_frame_d = !last;
      count_d    = last ? 7'd0 : count_nx;
      len_d      = len_eff;
      sum_d      = sum_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q     <= afb_pkg::LeadReset;
      in_frame_q <= 1'b0;
      count_q    <= 7'd0;
      len_q      <= 7'd0;
      sum_q      <= 16'd0;
    end else begin
      if (cfg_we_i) begin
        lead_q <= cfg_wdata_i;
      end
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      len_q      <= len_d;
      sum_q      <= sum_d;
    end
  end

  afb_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .item_i        (item),
    .can_load_o    (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  `AFB_ASSERT(a_count_below_len, in_frame_q |-> (count_q < len_q))
  `AFB_ASSERT(a_frame_closes, (accept && last) |=> (!in_frame_q && count_q == 7'd0))

endmodule

`default_nettype wire
